>>> rtl/core/grid_cell_extreme_z_decimation_core_defines.svh
`ifndef GRID_CELL_EXTREME_Z_DECIMATION_CORE_DEFINES_SVH
`define GRID_CELL_EXTREME_Z_DECIMATION_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GCEZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GCEZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/core/gcez_pkg.sv
package gcez_pkg;

  localparam int COORD_BITS      = 32;
  localparam int DIFF_BITS       = COORD_BITS + 1;
  localparam int EDGE_BITS       = 31;
  localparam int IDX_BITS        = 12;
  localparam int IN_DATA_BITS    = 112;
  localparam int OUT_DATA_BITS   = 8;
  localparam int DEF_MAX_POINTS  = 4096;
  localparam int DEF_GRID_SIDE   = 32;
  localparam logic [EDGE_BITS-1:0] EDGE_RESET = 31'd1000;

  typedef enum logic [1:0] {PH_EMPTY, PH_LOADING, PH_DONE} phase_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_GRID   = 2'd1,
    ST_POINTS = 2'd2,
    ST_INDEX  = 2'd3
  } status_t;

  typedef enum logic {ACT_LOAD, ACT_QUERY} action_t;
  typedef enum logic {REG_EDGE, REG_MODE} reg_idx_t;
  typedef enum logic {MODE_MAX, MODE_MIN} keep_mode_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GX_GO, S_GX_WT, S_GY_GO, S_GY_WT, S_CLR,
    S_PRD, S_PX_GO, S_PX_WT, S_PY_GO, S_PY_WT, S_CRD, S_CWR,
    S_Q1, S_Q2, S_Q3
  } seq_t;

  typedef struct packed {
    logic                 done;
    logic [DIFF_BITS-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/gcez_ram.sv
module gcez_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gcez_div.sv
module gcez_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gcez_pkg::DIFF_BITS-1:0] dividend,
  input  logic [gcez_pkg::EDGE_BITS-1:0] divisor,
  output gcez_pkg::div_rsp_t            rsp
);
  import gcez_pkg::*;

  localparam int CNT_W = $clog2(DIFF_BITS + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIFF_BITS-1:0] q_r;
  logic [EDGE_BITS-1:0] rem_r;
  logic [EDGE_BITS-1:0] dvs_r;
  logic [EDGE_BITS:0]   rem_sh;
  logic [EDGE_BITS:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_r, q_r[DIFF_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIFF_BITS);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[DIFF_BITS-2:0], ge};
        rem_r <= ge ? rem_sub[EDGE_BITS-1:0] : rem_sh[EDGE_BITS-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

>>> rtl/core/grid_cell_extreme_z_decimation_core.sv
// Channel  | Ports                        | Contents (lowest bit first)
// in       | in_tvalid/tready/tdata/tuser | tdata: x, y, z, index; tuser: action;
//          | in_tlast                     | tlast: last
// out      | out_tvalid/tready/tdata      | tdata: keep, status
// cfg      | cfg_valid/ready/index/data   | index 0 edge_length, 1 keep_mode
//
// A load is taken in S_IDLE; the load marked last, if no point overflowed,
// also builds the grid: the box check, then, if it passes, clearing the cell
// table and binning each point with the shared one-bit-per-cycle divider
// that runs twice per point. An errored query is answered from S_IDLE, else
// via S_Q1, S_Q2 and S_Q3. Reset is synchronous and clears control state
// only; no item is taken while a result waits on the output register.
module grid_cell_extreme_z_decimation_core #(
  parameter int MAX_POINTS = gcez_pkg::DEF_MAX_POINTS,
  parameter int GRID_SIDE  = gcez_pkg::DEF_GRID_SIDE
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gcez_pkg::IN_DATA_BITS-1:0]  in_tdata,   // x, y, z, index, zero pad
  input  logic                               in_tuser,   // action
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gcez_pkg::OUT_DATA_BITS-1:0] out_tdata,  // keep, status, zero pad
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [gcez_pkg::EDGE_BITS-1:0]     cfg_data
);
  import gcez_pkg::*;

  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int PW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CLW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int CMP_W = (CNT_W > IDX_BITS) ? CNT_W : IDX_BITS;
  localparam int CELL_W = 1 + PW + COORD_BITS;

  logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
  logic [IDX_BITS-1:0]          in_index;
  logic                         in_acc;

  assign in_x     = in_tdata[31:0];
  assign in_y     = in_tdata[63:32];
  assign in_z     = in_tdata[95:64];
  assign in_index = in_tdata[107:96];
  assign in_acc   = in_tvalid && in_tready;

  seq_t state_r, state_nxt;
  phase_t phase_r;
  status_t fault_r;
  logic [CNT_W-1:0] count_r;
  logic [EDGE_BITS-1:0] edge_r;
  keep_mode_t mode_r;
  logic signed [COORD_BITS-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic [CNT_W-1:0] i_r;
  logic [CW-1:0] clr_r;
  logic [CLW-1:0] col_r;
  logic [CW-1:0] c_r;
  logic gx_bad_r;
  logic [IDX_BITS-1:0] idx_r;
  logic out_valid_r, out_keep_r;
  status_t out_status_r;

  // load path
  logic done_ph, full;
  logic [CNT_W-1:0] cnt_e, cnt_ld;
  status_t flt_e, fault_ld, status_q;
  phase_t ph_e;

  assign done_ph  = phase_r == PH_DONE;
  assign cnt_e    = done_ph ? '0 : count_r;
  assign flt_e    = done_ph ? ST_OK : fault_r;
  assign ph_e     = done_ph ? PH_EMPTY : phase_r;
  assign full     = cnt_e >= CNT_W'(MAX_POINTS);
  assign fault_ld = full ? ST_POINTS : flt_e;
  assign cnt_ld   = full ? cnt_e : cnt_e + CNT_W'(1);

  always_comb begin
    if (done_ph && fault_r != ST_OK) begin
      status_q = fault_r;
    end else if (!done_ph || CMP_W'(in_index) >= CMP_W'(count_r)) begin
      status_q = ST_INDEX;
    end else begin
      status_q = ST_OK;
    end
  end

  // memories and divider
  logic [3*COORD_BITS-1:0] pt_wdata, pt_rdata;
  logic pt_we;
  logic [CW-1:0] pci_rdata;
  logic pci_we;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic [CW-1:0] cell_waddr, cell_raddr;
  logic cell_we;
  logic div_start;
  logic [DIFF_BITS-1:0] div_opnd;
  logic [EDGE_BITS-1:0] edge_eff;
  div_rsp_t div_rsp;

  logic signed [COORD_BITS-1:0] px, py, pz, bz;
  logic taken, better;
  logic [PW-1:0] bp;

  assign px = pt_rdata[COORD_BITS-1:0];
  assign py = pt_rdata[2*COORD_BITS-1:COORD_BITS];
  assign pz = pt_rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign {taken, bp, bz} = cell_rdata;
  assign better = (mode_r == MODE_MIN) ? (pz < bz) : (pz > bz);
  assign pt_wdata = {in_z, in_y, in_x};
  assign edge_eff = (edge_r == '0) ? EDGE_BITS'(1) : edge_r;

  gcez_ram #(.WIDTH(3*COORD_BITS), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(PW'(cnt_e)), .wdata(pt_wdata),
    .raddr(PW'(i_r)), .rdata(pt_rdata)
  );

  gcez_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_pci_ram (
    .clk(clk), .we(pci_we), .waddr(PW'(i_r)), .wdata(c_r),
    .raddr(PW'(idx_r)), .rdata(pci_rdata)
  );

  gcez_ram #(.WIDTH(CELL_W), .DEPTH(NUM_CELLS)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  gcez_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_opnd),
    .divisor(edge_eff), .rsp(div_rsp)
  );

  function automatic logic [DIFF_BITS-1:0] offs(logic signed [COORD_BITS-1:0] v,
                                                 logic signed [COORD_BITS-1:0] b);
    return {v[COORD_BITS-1], v} - {b[COORD_BITS-1], b};
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (action_t'(in_tuser) == ACT_LOAD) begin
            if (in_tlast && fault_ld == ST_OK && cnt_ld != '0) state_nxt = S_GX_GO;
          end else if (status_q == ST_OK) begin
            state_nxt = S_Q1;
          end
        end
      end
      S_GX_GO: state_nxt = S_GX_WT;
      S_GX_WT: if (div_rsp.done) state_nxt = S_GY_GO;
      S_GY_GO: state_nxt = S_GY_WT;
      S_GY_WT: begin
        if (div_rsp.done) begin
          if (gx_bad_r || div_rsp.quot >= DIFF_BITS'(GRID_SIDE)) state_nxt = S_IDLE;
          else state_nxt = S_CLR;
        end
      end
      S_CLR:   if (clr_r == CW'(NUM_CELLS - 1)) state_nxt = S_PRD;
      S_PRD:   state_nxt = S_PX_GO;
      S_PX_GO: state_nxt = S_PX_WT;
      S_PX_WT: if (div_rsp.done) state_nxt = S_PY_GO;
      S_PY_GO: state_nxt = S_PY_WT;
      S_PY_WT: if (div_rsp.done) state_nxt = S_CRD;
      S_CRD:   state_nxt = S_CWR;
      S_CWR:   state_nxt = (i_r + CNT_W'(1) == count_r) ? S_IDLE : S_PRD;
      S_Q1:    state_nxt = S_Q2;
      S_Q2:    state_nxt = S_Q3;
      S_Q3:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    pt_we      = 1'b0;
    pci_we     = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = c_r;
    cell_wdata = {1'b1, PW'(i_r), pz};
    cell_raddr = pci_rdata;
    div_start  = 1'b0;
    div_opnd   = offs(px, min_x_r);
    case (state_r)
      S_IDLE: begin
        in_tready = !out_valid_r;
        pt_we     = in_acc && action_t'(in_tuser) == ACT_LOAD && !full;
      end
      S_GX_GO: begin
        div_start = 1'b1;
        div_opnd  = offs(max_x_r, min_x_r);
      end
      S_GY_GO: begin
        div_start = 1'b1;
        div_opnd  = offs(max_y_r, min_y_r);
      end
      S_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_r;
        cell_wdata = '0;
      end
      S_PX_GO: div_start = 1'b1;
      S_PY_GO: begin
        div_start = 1'b1;
        div_opnd  = offs(py, min_y_r);
      end
      S_CRD: cell_raddr = c_r;
      S_CWR: begin
        pci_we  = 1'b1;
        cell_we = !taken || better;
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_status_r, out_keep_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_EMPTY;
      fault_r     <= ST_OK;
      count_r     <= '0;
      edge_r      <= EDGE_RESET;
      mode_r      <= MODE_MAX;
      out_valid_r <= 1'b0;
      min_x_r     <= '0;
      min_y_r     <= '0;
      max_x_r     <= '0;
      max_y_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        if (reg_idx_t'(cfg_index) == REG_EDGE) edge_r <= cfg_data;
        else mode_r <= keep_mode_t'(cfg_data[0]);
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc && action_t'(in_tuser) == ACT_LOAD) begin
            fault_r <= fault_ld;
            count_r <= cnt_ld;
            phase_r <= in_tlast ? PH_DONE : (full ? ph_e : PH_LOADING);
            if (!full) begin
              if (ph_e == PH_EMPTY) begin
                min_x_r <= in_x;
                max_x_r <= in_x;
                min_y_r <= in_y;
                max_y_r <= in_y;
              end else begin
                if (in_x < min_x_r) min_x_r <= in_x;
                if (in_x > max_x_r) max_x_r <= in_x;
                if (in_y < min_y_r) min_y_r <= in_y;
                if (in_y > max_y_r) max_y_r <= in_y;
              end
            end
          end else if (in_acc) begin
            idx_r <= in_index;
            if (status_q != ST_OK) begin
              out_valid_r  <= 1'b1;
              out_keep_r   <= 1'b0;
              out_status_r <= status_q;
            end
          end
          i_r   <= '0;
          clr_r <= '0;
        end
        S_GX_WT: if (div_rsp.done) gx_bad_r <= div_rsp.quot >= DIFF_BITS'(GRID_SIDE);
        S_GY_WT: begin
          if (div_rsp.done && (gx_bad_r || div_rsp.quot >= DIFF_BITS'(GRID_SIDE))) begin
            fault_r <= ST_GRID;
          end
        end
        S_CLR:   clr_r <= clr_r + CW'(1);
        S_PX_WT: if (div_rsp.done) col_r <= div_rsp.quot[CLW-1:0];
        S_PY_WT: begin
          if (div_rsp.done) begin
            c_r <= CW'(div_rsp.quot[CLW-1:0] * GRID_SIDE + col_r);
          end
        end
        S_CWR: i_r <= i_r + CNT_W'(1);
        S_Q3: begin
          out_valid_r  <= 1'b1;
          out_keep_r   <= taken && bp == PW'(idx_r);
          out_status_r <= ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/gcez_chk.sv
module gcez_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [gcez_pkg::OUT_DATA_BITS-1:0] out_tdata
);
  import gcez_pkg::*;
  `include "grid_cell_extreme_z_decimation_core_defines.svh"

  `GCEZ_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `GCEZ_ASSERT_IMP(a_no_take_pending, in_tready, !out_tvalid)
  `GCEZ_ASSERT_NXT(a_load_silent, in_tvalid && in_tready && !in_tuser, !out_tvalid)
  `GCEZ_ASSERT_IMP(a_keep_ok_only, out_tvalid && out_tdata[0], out_tdata[2:1] == ST_OK)

endmodule

bind grid_cell_extreme_z_decimation_core gcez_chk u_gcez_chk (.*);
